// ===== hw/rtl/bdct_pkg.sv =====
// ----------------------------------------------------------------------------
// bdct_pkg: shared types and constants for the 8x8 dct / idct block
// Holds the sequencer states, fixed-point formats and the cosine basis.
// ----------------------------------------------------------------------------
package bdct_pkg;

  localparam int unsigned SideBits  = 3;                    // log2 of block side
  localparam int unsigned AreaBits  = 2 * SideBits;         // log2 of block area
  localparam int unsigned SampleW   = 16;                   // input / output word
  localparam int unsigned MidW      = 24;                   // row-pass values
  localparam int unsigned CoefW     = 16;                   // basis constants
  localparam int unsigned CoefBitsW = 4;                    // log2 of CoefW
  localparam int unsigned AccW      = 43;                   // column-pass sum
  localparam int unsigned RowShift  = 10;                   // cos frac - guard
  localparam int unsigned ColShift  = 18;                   // cos frac + guard

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_FETCH,
    ST_MUL,
    ST_STORE,
    ST_EMIT
  } bdct_state_e;

  // 8192 * cos(m * pi / 16), rounded
  function automatic logic [CoefW-1:0] bdct_cos_mag(input int unsigned m);
    logic [CoefW-1:0] mag;
    case (m)
      0: mag = 16'd8192;
      1: mag = 16'd8035;
      2: mag = 16'd7568;
      3: mag = 16'd6811;
      4: mag = 16'd5793;
      5: mag = 16'd4551;
      6: mag = 16'd3135;
      7: mag = 16'd1598;
      default: mag = 16'd0;
    endcase
    return mag;
  endfunction

  // orthonormal basis k[u][x] with 14 fraction bits
  function automatic logic signed [CoefW-1:0] bdct_basis(input logic [SideBits-1:0] u,
                                                         input logic [SideBits-1:0] x);
    int unsigned      m;
    logic             neg;
    logic [CoefW-1:0] mag;
    m   = ((2 * int'(x) + 1) * int'(u)) % 32;
    neg = 1'b0;
    if (m > 16) begin
      m = 32 - m;
    end
    if (m > 8) begin
      m   = 16 - m;
      neg = 1'b1;
    end
    if (u == '0) begin
      mag = 16'd5793;
    end else begin
      mag = bdct_cos_mag(m);
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== hw/rtl/block_dct_idct_8x8_top.sv =====
// ----------------------------------------------------------------------------
// block_dct_idct_8x8_top: 2-d orthonormal dct-ii / inverse dct on 8x8 blocks
// Row pass into a transpose memory, then column pass; each product is formed
// bit-serially over the 16 coefficient bits on one shared accumulator.
// ----------------------------------------------------------------------------
// each product is a read, a fetch and 16 bit-serial add steps; each element is
// 8 products plus one store, for a row pass and then a column pass
// the column pass emits each element and holds while the output is stalled;
//   no new block is taken in until the last word of the current one is accepted
// reset: direction 0, sample count 0, sequencer idle and ready; stores undefined
module block_dct_idct_8x8_top import bdct_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] value_out_o,
  output logic [AreaBits-1:0]       position_o,
  output logic                      block_end_o
);

  localparam logic [SideBits-1:0]  SideLast  = '1;
  localparam logic [AreaBits-1:0]  AreaLast  = '1;
  localparam logic [CoefBitsW-1:0] BitLast   = '1;
  localparam logic signed [AccW-1:0] RowRound = AccW'(1) <<< (RowShift - 1);
  localparam logic signed [AccW-1:0] ColRound = AccW'(1) <<< (ColShift - 1);
  localparam logic signed [AccW-1:0] MidMax   = (AccW'(1) <<< (MidW - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] MidMin   = -(AccW'(1) <<< (MidW - 1));
  localparam logic signed [AccW-1:0] OutMax   = (AccW'(1) <<< (SampleW - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] OutMin   = -(AccW'(1) <<< (SampleW - 1));

  bdct_state_e state_q, state_d;

  logic                      dir_q, dir_d, blk_dir_q, blk_dir_d;
  logic [AreaBits-1:0]       cnt_q, cnt_d;
  logic                      col_q, col_d;
  logic [SideBits-1:0]       r_q, r_d, c_q, c_d, k_q, k_d;
  logic [CoefBitsW-1:0]      bit_q, bit_d;
  logic signed [AccW-1:0]    mcand_q, mcand_d;
  logic [CoefW-1:0]          mult_q, mult_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [SampleW-1:0] out_val_q, out_val_d;
  logic [AreaBits-1:0]       out_pos_q, out_pos_d;
  logic                      out_end_q, out_end_d;

  logic signed [SampleW-1:0] blk_mem [2**AreaBits];
  logic signed [MidW-1:0]    mid_mem [2**AreaBits];
  logic signed [SampleW-1:0] blk_rd_q;
  logic signed [MidW-1:0]    mid_rd_q;
  logic                      blk_we, mid_we;
  logic signed [MidW-1:0]    mid_wdata;

  logic signed [AccW-1:0]    row_scaled, col_scaled;
  logic signed [CoefW-1:0]   coef;
  logic [SideBits-1:0]       cu, cx;
  logic                      in_acc, out_acc, elem_last;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // sample buffer and transpose buffer, registered reads
  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[cnt_q] <= sample_in_i;
    end
    if (mid_we) begin
      mid_mem[{r_q, c_q}] <= mid_wdata;
    end
    blk_rd_q <= blk_mem[{r_q, k_q}];
    mid_rd_q <= mid_mem[{k_q, c_q}];
  end

  // basis select: forward uses k[out][in], inverse k[in][out]
  always_comb begin
    if (!col_q) begin
      cu = blk_dir_q ? k_q : c_q;
      cx = blk_dir_q ? c_q : k_q;
    end else begin
      cu = blk_dir_q ? k_q : r_q;
      cx = blk_dir_q ? r_q : k_q;
    end
    coef = bdct_basis(cu, cx);
  end

  // rounding half up of the finished sums and saturation of the row-pass sum
  always_comb begin
    row_scaled = (acc_q + RowRound) >>> RowShift;
    col_scaled = (acc_q + ColRound) >>> ColShift;
    if (row_scaled > MidMax) begin
      mid_wdata = MidMax[MidW-1:0];
    end else if (row_scaled < MidMin) begin
      mid_wdata = MidMin[MidW-1:0];
    end else begin
      mid_wdata = row_scaled[MidW-1:0];
    end
  end

  assign elem_last = (r_q == SideLast) && (c_q == SideLast);

  // sequencer: next state and datapath
  always_comb begin
    state_d   = state_q;
    dir_d     = cfg_we_i ? cfg_data_i : dir_q;
    blk_dir_d = blk_dir_q;
    cnt_d     = cnt_q;
    col_d     = col_q;
    r_d       = r_q;
    c_d       = c_q;
    k_d       = k_q;
    bit_d     = bit_q;
    mcand_d   = mcand_q;
    mult_d    = mult_q;
    acc_d     = acc_q;
    out_val_d = out_val_q;
    out_pos_d = out_pos_q;
    out_end_d = out_end_q;
    blk_we    = 1'b0;
    mid_we    = 1'b0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          blk_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          if (cnt_q == AreaLast) begin
            blk_dir_d = dir_q;
            col_d     = 1'b0;
            r_d       = '0;
            c_d       = '0;
            k_d       = '0;
            state_d   = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        mcand_d = col_q ? AccW'(mid_rd_q) : AccW'(blk_rd_q);
        mult_d  = coef;
        bit_d   = '0;
        if (k_q == '0) begin
          acc_d = '0;
        end
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // one coefficient bit per cycle, sign bit weighs negative
        if (mult_q[0]) begin
          acc_d = (bit_q == BitLast) ? acc_q - mcand_q : acc_q + mcand_q;
        end
        mcand_d = mcand_q <<< 1;
        mult_d  = mult_q >> 1;
        bit_d   = bit_q + 1'b1;
        if (bit_q == BitLast) begin
          if (k_q == SideLast) begin
            state_d = ST_STORE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_STORE: begin
        k_d = '0;
        if (!col_q) begin
          mid_we  = 1'b1;
          c_d     = c_q + 1'b1;
          state_d = ST_READ;
          if (c_q == SideLast) begin
            r_d = r_q + 1'b1;
          end
          if (elem_last) begin
            col_d = 1'b1;
          end
        end else begin
          if (col_scaled > OutMax) begin
            out_val_d = OutMax[SampleW-1:0];
          end else if (col_scaled < OutMin) begin
            out_val_d = OutMin[SampleW-1:0];
          end else begin
            out_val_d = col_scaled[SampleW-1:0];
          end
          out_pos_d = {r_q, c_q};
          out_end_d = elem_last;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_acc) begin
          c_d = c_q + 1'b1;
          if (c_q == SideLast) begin
            r_d = r_q + 1'b1;
          end
          if (elem_last) begin
            cnt_d   = '0;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      dir_q     <= 1'b0;
      blk_dir_q <= 1'b0;
      cnt_q     <= '0;
      col_q     <= 1'b0;
      r_q       <= '0;
      c_q       <= '0;
      k_q       <= '0;
      bit_q     <= '0;
    end else begin
      state_q   <= state_d;
      dir_q     <= dir_d;
      blk_dir_q <= blk_dir_d;
      cnt_q     <= cnt_d;
      col_q     <= col_d;
      r_q       <= r_d;
      c_q       <= c_d;
      k_q       <= k_d;
      bit_q     <= bit_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mcand_q   <= mcand_d;
    mult_q    <= mult_d;
    acc_q     <= acc_d;
    out_val_q <= out_val_d;
    out_pos_q <= out_pos_d;
    out_end_q <= out_end_d;
  end

  assign value_out_o = out_val_q;
  assign position_o  = out_pos_q;
  assign block_end_o = out_end_q;

endmodule

// ===== sim/dct_idct_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dct_idct_checker: scoreboard for the 8x8 dct / idct block
// Watches the input and output channels and the direction register, works out
// each transformed block in fixed point and compares every output word.
// ----------------------------------------------------------------------------
module dct_idct_checker import bdct_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [SampleW-1:0] sample_in_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [SampleW-1:0] value_out_i,
  input  logic [AreaBits-1:0]       position_i,
  input  logic                      block_end_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        result_count_o
);

  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic [AreaBits-1:0]       pos;
    logic                      last;
  } dct_word_t;

  localparam real PI = 3.14159265358979323846;

  dct_word_t   expected_words[$];
  longint      coef[8][8];
  longint      pixel_buf[64];
  longint      row_buf[64];
  int unsigned fill_count;
  logic        inverse_mode;

  // basis with 14 fraction bits, index 0 weighted by 1/sqrt2
  initial begin
    real c;
    for (int u = 0; u < 8; u++) begin
      for (int x = 0; x < 8; x++) begin
        if (u == 0) begin
          c = 16384.0 / $sqrt(8.0);
        end else begin
          c = 8192.0 * $cos((2 * x + 1) * u * PI / 16.0);
        end
        coef[u][x] = longint'($rtoi($floor(c + 0.5)));
      end
    end
  end

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // rescale with rounding half toward plus infinity
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // row pass into the transpose buffer, then column pass into the queue
  task automatic transform_block();
    longint    acc;
    longint    w;
    dct_word_t word;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        acc = 0;
        for (int k = 0; k < 8; k++) begin
          w = inverse_mode ? coef[k][c] : coef[c][k];
          acc += w * pixel_buf[r * 8 + k];
        end
        row_buf[r * 8 + c] = clamp(round_shift(acc, RowShift), MidW);
      end
    end
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        acc = 0;
        for (int k = 0; k < 8; k++) begin
          w = inverse_mode ? coef[k][r] : coef[r][k];
          acc += w * row_buf[k * 8 + c];
        end
        word.value = SampleW'(clamp(round_shift(acc, ColShift), SampleW));
        word.pos   = AreaBits'(r * 8 + c);
        word.last  = (r * 8 + c == 63);
        expected_words.push_back(word);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o   = 0;
    result_count_o = 0;
    fill_count     = 0;
    inverse_mode   = 1'b0;
  end

  assign pending_o = expected_words.size();

  // register and input side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        inverse_mode = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        pixel_buf[fill_count] = longint'(sample_in_i);
        fill_count++;
        if (fill_count == 64) begin
          fill_count = 0;
          transform_block();
        end
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    dct_word_t exp_word;
    if (rst_ni && out_valid_i && !out_stall_i) begin
      result_count_o++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word value %0d position %0d",
                                  value_out_i, position_i));
      end else begin
        exp_word = expected_words.pop_front();
        if (value_out_i !== exp_word.value) begin
          report_mismatch($sformatf("position %0d value %0d, expected %0d",
                                    exp_word.pos, value_out_i, exp_word.value));
        end
        if (position_i !== exp_word.pos) begin
          report_mismatch($sformatf("position %0d, expected %0d",
                                    position_i, exp_word.pos));
        end
        if (block_end_i !== exp_word.last) begin
          report_mismatch($sformatf("position %0d block end %0b, expected %0b",
                                    exp_word.pos, block_end_i, exp_word.last));
        end
      end
    end
  end

endmodule

// ===== sim/tb_block_dct_idct_8x8_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_dct_idct_8x8_top: testbench for the 8x8 dct / idct block
// Streams blocks of samples in both directions with random gaps and output
// stalls, including one long output hold-off; a checker module scores results.
// ----------------------------------------------------------------------------
module tb_block_dct_idct_8x8_top;
  import bdct_pkg::*;

  localparam int CycleLimit = 2000000;

  typedef enum int {
    FILL_DIRECTED,
    FILL_PIXEL,
    FILL_FULL,
    FILL_SMALL
  } fill_mode_e;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic                      cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_in_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [SampleW-1:0] value_out_o;
  logic [AreaBits-1:0]       position_o;
  logic                      block_end_o;
  int                        fail_count;
  int                        pending;
  int                        result_count;
  int                        cycle_count;

  block_dct_idct_8x8_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_out_o (value_out_o),
    .position_o  (position_o),
    .block_end_o (block_end_o)
  );

  dct_idct_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .sample_in_i    (sample_in_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_out_i    (value_out_o),
    .position_i     (position_o),
    .block_end_i    (block_end_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("tb_block_dct_idct_8x8_top failed");
        $finish;
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 65) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(4, 1);
    end
    return $urandom_range(200, 20);
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample(input fill_mode_e mode,
                                                            input int idx);
    logic signed [SampleW-1:0] v;
    case (mode)
      FILL_DIRECTED: begin
        // extremes up front, the rest at full scale to drive saturation
        case (idx)
          0: v = 16'sh7fff;
          1: v = 16'sh8000;
          2: v = 16'sh0000;
          3: v = 16'shffff;
          4: v = 16'sh0001;
          5: v = 16'sh5555;
          6: v = 16'shaaaa;
          7: v = 16'sh8001;
          default: v = (idx < 24 && idx[0]) ? 16'sh8000 : 16'sh7fff;
        endcase
      end
      FILL_PIXEL: v = SampleW'($urandom_range(255) * 16);
      FILL_SMALL: v = SampleW'(int'($urandom_range(1023)) - 512);
      default:    v = SampleW'($urandom());
    endcase
    return v;
  endfunction

  // one word on the input channel, then an optional gap
  task automatic send_word(input logic signed [SampleW-1:0] v);
    int gap;
    in_valid_i  <= 1'b1;
    sample_in_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap = gap_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until every expected word has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_direction(input logic dir);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= dir;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // first the direction, then 64 words, optionally writing the opposite direction and back at mid block
  task automatic run_block(input logic dir, input fill_mode_e mode,
                           input logic flip_mid);
    write_direction(dir);
    for (int i = 0; i < 64; i++) begin
      if (flip_mid && i == 32) begin
        wait_idle();
        write_direction(~dir);
        write_direction(dir);
      end
      send_word(pick_sample(mode, i));
    end
    wait_idle();
  endtask

  // output stall: random pattern plus one long hold-off
  initial begin
    logic held;
    int   r;
    out_stall_i = 1'b0;
    held        = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && result_count >= 130) begin
        out_stall_i <= 1'b1;
        repeat (25000) @(posedge clk_i);
        held = 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 50) begin
          out_stall_i <= 1'b0;
          repeat ($urandom_range(40, 1)) @(posedge clk_i);
        end else if (r < 92) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(4, 1)) @(posedge clk_i);
        end else begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(150, 20)) @(posedge clk_i);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = 1'b0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_block(1'b0, FILL_DIRECTED, 1'b0);
    run_block(1'b1, FILL_DIRECTED, 1'b0);
    // second block is sent without waiting so the long hold-off backs up input
    write_direction(1'b0);
    for (int i = 0; i < 64; i++) send_word(pick_sample(FILL_PIXEL, i));
    for (int i = 0; i < 64; i++) send_word(pick_sample(FILL_SMALL, i));
    wait_idle();
    run_block(1'b1, FILL_FULL, 1'b1);

    repeat (1000) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_block_dct_idct_8x8_top passed");
    end else begin
      $display("tb_block_dct_idct_8x8_top failed");
    end
    $finish;
  end

endmodule
